[sv/sic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sic_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int THRESH_WIDTH        = 20;
    localparam int CLASS_WIDTH         = 3;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1);

    localparam logic [CLASS_WIDTH-1:0] CLASS_BOTH     = 3'd0;
    localparam logic [CLASS_WIDTH-1:0] CLASS_FIRST    = 3'd1;
    localparam logic [CLASS_WIDTH-1:0] CLASS_SECOND   = 3'd2;
    localparam logic [CLASS_WIDTH-1:0] CLASS_NEITHER  = 3'd3;
    localparam logic [CLASS_WIDTH-1:0] CLASS_PARALLEL = 3'd4;

    // Control that travels alongside the division data down the cell chain.
    typedef struct packed {
        logic                   valid;
        logic [CLASS_WIDTH-1:0] cls;
        logic                   neg_x;
        logic                   neg_y;
        logic                   sat_x;
        logic                   sat_y;
    } sic_ctrl_t;

endpackage

`default_nettype wire

[sv/segment_intersection_classifier_unit.sv]
// An accepted item passes through the front stages, the division cells and the output register.
// Throughput: one item per cycle unless stalled; six front stages, one division cell per quotient bit.
// The whole pipeline advances together and halts only while a result waits untaken.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the
// parallel threshold to 1; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_classifier_unit
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [THRESH_WIDTH-1:0]       cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] first_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] first_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_end_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [CLASS_WIDTH-1:0]             crossing_class,
    output logic signed [COORD_WIDTH-1:0]      crossing_x,
    output logic signed [COORD_WIDTH-1:0]      crossing_y
);

    localparam int PW = 2 * (COORD_WIDTH + 1) + 1;
    localparam int NW = PW + COORD_WIDTH + 2;
    localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [THRESH_WIDTH-1:0] thr_reg;
    logic                    en;

    // The pipeline moves whenever the output register is empty or being
    // drained, so a waiting result never blocks an item already behind it
    // from being accepted once the consumer takes it.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESH_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // Chain of division cells: index 0 is fed by the front end, cell k
    // decides quotient bit COORD_WIDTH-1-k of both coordinates.
    sic_ctrl_t              ctrl_c [0:COORD_WIDTH];
    logic [PW-1:0]          d_c    [0:COORD_WIDTH];
    logic [NW-1:0]          rx_c   [0:COORD_WIDTH];
    logic [NW-1:0]          ry_c   [0:COORD_WIDTH];
    logic [COORD_WIDTH-1:0] qx_c   [0:COORD_WIDTH];
    logic [COORD_WIDTH-1:0] qy_c   [0:COORD_WIDTH];

    sic_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .threshold      (thr_reg),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .ctrl_out       (ctrl_c[0]),
        .dabs_out       (d_c[0]),
        .nx_out         (rx_c[0]),
        .ny_out         (ry_c[0])
    );

    assign qx_c[0] = '0;
    assign qy_c[0] = '0;

    for (genvar k = 0; k < COORD_WIDTH; k++)
    begin : g_cell
        sic_div_cell #(
            .COORD_WIDTH(COORD_WIDTH),
            .SHIFT      (COORD_WIDTH - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_c[k]),
            .d_in     (d_c[k]),
            .rx_in    (rx_c[k]),
            .ry_in    (ry_c[k]),
            .qx_in    (qx_c[k]),
            .qy_in    (qy_c[k]),
            .ctrl_out (ctrl_c[k+1]),
            .d_out    (d_c[k+1]),
            .rx_out   (rx_c[k+1]),
            .ry_out   (ry_c[k+1]),
            .qx_out   (qx_c[k+1]),
            .qy_out   (qy_c[k+1])
        );
    end

    // Apply the sign to the truncated magnitude and saturate; a parallel item gives
    // zero. Otherwise a magnitude flagged as out of range in the front end
    // saturates regardless of the quotient bits.
    sic_ctrl_t              cf;
    logic [COORD_WIDTH-1:0] qx, qy, x_next, y_next;

    always_comb
    begin
        cf = ctrl_c[COORD_WIDTH];
        qx = qx_c[COORD_WIDTH];
        qy = qy_c[COORD_WIDTH];
        if (cf.cls == CLASS_PARALLEL)
            x_next = '0;
        else if (cf.neg_x)
            x_next = (cf.sat_x || qx > NEG_MIN) ? NEG_MIN : COORD_WIDTH'(-qx);
        else
            x_next = (cf.sat_x || qx > POS_MAX) ? POS_MAX : qx;
        if (cf.cls == CLASS_PARALLEL)
            y_next = '0;
        else if (cf.neg_y)
            y_next = (cf.sat_y || qy > NEG_MIN) ? NEG_MIN : COORD_WIDTH'(-qy);
        else
            y_next = (cf.sat_y || qy > POS_MAX) ? POS_MAX : qy;
    end

    logic                   out_valid_reg;
    logic [CLASS_WIDTH-1:0] class_reg;
    logic [COORD_WIDTH-1:0] x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cf.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            class_reg <= cf.cls;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign crossing_class = class_reg;
    assign crossing_x     = x_reg;
    assign crossing_y     = y_reg;

`ifndef SYNTHESIS
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crossing_class == CLASS_PARALLEL |-> crossing_x == '0 && crossing_y == '0)
        else $error("parallel item with nonzero coordinates");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stage");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctrl_c[0]) && $stable(cf))
        else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

[sv/sic_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sic_front
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW + 1,
    localparam int NW = PW + COORD_WIDTH + 2
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [THRESH_WIDTH-1:0]       threshold,
    input  wire logic signed [COORD_WIDTH-1:0] first_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] first_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_end_y,
    output sic_ctrl_t                          ctrl_out,
    output logic [PW-1:0]                      dabs_out,
    output logic [NW-1:0]                      nx_out,
    output logic [NW-1:0]                      ny_out
);

    localparam int CW = (PW > THRESH_WIDTH) ? PW : THRESH_WIDTH;

    // Stage 1: differences.
    logic                          v1_reg;
    logic signed [DW-1:0]          d1x_reg, d1y_reg, d2x_reg, d2y_reg, ox_reg, oy_reg;
    logic signed [COORD_WIDTH-1:0] fx0_1_reg, fy0_1_reg;
    // Stage 2: products.
    logic                          v2_reg;
    logic signed [2*DW-1:0]        p_den_a_reg, p_den_b_reg, p_na_a_reg, p_na_b_reg;
    logic signed [2*DW-1:0]        p_nb_a_reg, p_nb_b_reg;
    logic signed [DW-1:0]          d1x_2_reg, d1y_2_reg;
    logic signed [COORD_WIDTH-1:0] fx0_2_reg, fy0_2_reg;
    // Stage 3: denominator, numerators, classification.
    logic                          v3_reg;
    logic [CLASS_WIDTH-1:0]        cls3_reg;
    logic signed [PW-1:0]          den_reg, na_reg;
    logic signed [DW-1:0]          d1x_3_reg, d1y_3_reg;
    logic signed [COORD_WIDTH-1:0] fx0_3_reg, fy0_3_reg;
    // Stage 4: coordinate numerator products.
    logic                          v4_reg;
    logic [CLASS_WIDTH-1:0]        cls4_reg;
    logic signed [NW-2:0]          xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [PW-1:0]          den4_reg;
    // Stage 5: numerator sums as sign and magnitude.
    logic                          v5_reg, negx5_reg, negy5_reg;
    logic [CLASS_WIDTH-1:0]        cls5_reg;
    logic [NW-1:0]                 nx5_reg, ny5_reg;
    logic [PW-1:0]                 dabs5_reg;
    // Stage 6: overflow check against the coordinate range.
    sic_ctrl_t                     ctrl6_reg;
    logic [PW-1:0]                 dabs6_reg;
    logic [NW-1:0]                 nx6_reg, ny6_reg;

    logic signed [PW-1:0] den_next, na_next, nb_next;
    logic [PW-1:0]        den_abs, na_abs, nb_abs;
    logic [CW-1:0]        den_cmp, thr_cmp;
    logic                 par_next, on_a, on_b;
    logic [CLASS_WIDTH-1:0] cls_next;
    logic signed [NW-1:0] nx_next, ny_next;
    logic [NW-1:0]        dlim;

    always_comb
    begin
        den_next = PW'(p_den_a_reg) - PW'(p_den_b_reg);
        na_next  = PW'(p_na_a_reg) - PW'(p_na_b_reg);
        nb_next  = PW'(p_nb_a_reg) - PW'(p_nb_b_reg);
        den_abs  = den_next[PW-1] ? PW'(-den_next) : PW'(den_next);
        na_abs   = na_next[PW-1] ? PW'(-na_next) : PW'(na_next);
        nb_abs   = nb_next[PW-1] ? PW'(-nb_next) : PW'(nb_next);
        den_cmp  = CW'(den_abs);
        thr_cmp  = CW'(threshold);
        par_next = (den_next == '0) || (den_cmp < thr_cmp);
        // A parameter lies in [0,1] when its numerator is zero, or has the
        // denominator's sign and no greater magnitude.
        on_a = (na_next == '0) || ((na_next[PW-1] == den_next[PW-1]) && (na_abs <= den_abs));
        on_b = (nb_next == '0) || ((nb_next[PW-1] == den_next[PW-1]) && (nb_abs <= den_abs));
        priority if (par_next)
            cls_next = CLASS_PARALLEL;
        else if (on_a && on_b)
            cls_next = CLASS_BOTH;
        else if (on_a)
            cls_next = CLASS_FIRST;
        else if (on_b)
            cls_next = CLASS_SECOND;
        else
            cls_next = CLASS_NEITHER;
        nx_next = NW'(xa_reg) + NW'(xb_reg);
        ny_next = NW'(ya_reg) + NW'(yb_reg);
        dlim    = NW'(dabs5_reg) << COORD_WIDTH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            ctrl6_reg <= '0;
        end
        else if (en)
        begin
            v1_reg          <= in_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            v5_reg          <= v4_reg;
            ctrl6_reg.valid <= v5_reg;
            ctrl6_reg.cls   <= cls5_reg;
            ctrl6_reg.neg_x <= negx5_reg;
            ctrl6_reg.neg_y <= negy5_reg;
            ctrl6_reg.sat_x <= nx5_reg >= dlim;
            ctrl6_reg.sat_y <= ny5_reg >= dlim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg   <= DW'(first_end_x) - DW'(first_start_x);
            d1y_reg   <= DW'(first_end_y) - DW'(first_start_y);
            d2x_reg   <= DW'(second_end_x) - DW'(second_start_x);
            d2y_reg   <= DW'(second_end_y) - DW'(second_start_y);
            ox_reg    <= DW'(first_start_x) - DW'(second_start_x);
            oy_reg    <= DW'(first_start_y) - DW'(second_start_y);
            fx0_1_reg <= first_start_x;
            fy0_1_reg <= first_start_y;

            p_den_a_reg <= d2y_reg * d1x_reg;
            p_den_b_reg <= d2x_reg * d1y_reg;
            p_na_a_reg  <= d2x_reg * oy_reg;
            p_na_b_reg  <= d2y_reg * ox_reg;
            p_nb_a_reg  <= d1x_reg * oy_reg;
            p_nb_b_reg  <= d1y_reg * ox_reg;
            d1x_2_reg   <= d1x_reg;
            d1y_2_reg   <= d1y_reg;
            fx0_2_reg   <= fx0_1_reg;
            fy0_2_reg   <= fy0_1_reg;

            den_reg   <= den_next;
            na_reg    <= na_next;
            cls3_reg  <= cls_next;
            d1x_3_reg <= d1x_2_reg;
            d1y_3_reg <= d1y_2_reg;
            fx0_3_reg <= fx0_2_reg;
            fy0_3_reg <= fy0_2_reg;

            xa_reg   <= fx0_3_reg * den_reg;
            xb_reg   <= na_reg * d1x_3_reg;
            ya_reg   <= fy0_3_reg * den_reg;
            yb_reg   <= na_reg * d1y_3_reg;
            den4_reg <= den_reg;
            cls4_reg <= cls3_reg;

            nx5_reg   <= nx_next[NW-1] ? NW'(-nx_next) : NW'(nx_next);
            ny5_reg   <= ny_next[NW-1] ? NW'(-ny_next) : NW'(ny_next);
            negx5_reg <= nx_next[NW-1] ^ den4_reg[PW-1];
            negy5_reg <= ny_next[NW-1] ^ den4_reg[PW-1];
            dabs5_reg <= den4_reg[PW-1] ? PW'(-den4_reg) : PW'(den4_reg);
            cls5_reg  <= cls4_reg;

            dabs6_reg <= dabs5_reg;
            nx6_reg   <= nx5_reg;
            ny6_reg   <= ny5_reg;
        end
    end

    assign ctrl_out = ctrl6_reg;
    assign dabs_out = dabs6_reg;
    assign nx_out   = nx6_reg;
    assign ny_out   = ny6_reg;

endmodule

`default_nettype wire

[sv/sic_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step for both coordinates: decides quotient bit SHIFT.
module sic_div_cell
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
    parameter int SHIFT       = 0,
    localparam int PW = 2 * (COORD_WIDTH + 1) + 1,
    localparam int NW = PW + COORD_WIDTH + 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire sic_ctrl_t              ctrl_in,
    input  wire logic [PW-1:0]          d_in,
    input  wire logic [NW-1:0]          rx_in,
    input  wire logic [NW-1:0]          ry_in,
    input  wire logic [COORD_WIDTH-1:0] qx_in,
    input  wire logic [COORD_WIDTH-1:0] qy_in,
    output sic_ctrl_t                   ctrl_out,
    output logic [PW-1:0]               d_out,
    output logic [NW-1:0]               rx_out,
    output logic [NW-1:0]               ry_out,
    output logic [COORD_WIDTH-1:0]      qx_out,
    output logic [COORD_WIDTH-1:0]      qy_out
);

    sic_ctrl_t              ctrl_reg;
    logic [PW-1:0]          d_reg;
    logic [NW-1:0]          rx_reg, ry_reg;
    logic [COORD_WIDTH-1:0] qx_reg, qy_reg;

    logic [NW-1:0]          ds;
    logic                   gex, gey;
    logic [COORD_WIDTH-1:0] qx_next, qy_next;

    always_comb
    begin
        ds      = NW'(d_in) << SHIFT;
        gex     = rx_in >= ds;
        gey     = ry_in >= ds;
        qx_next = qx_in;
        qy_next = qy_in;
        qx_next[SHIFT] = gex;
        qy_next[SHIFT] = gey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg  <= d_in;
            rx_reg <= gex ? rx_in - ds : rx_in;
            ry_reg <= gey ? ry_in - ds : ry_in;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign d_out    = d_reg;
    assign rx_out   = rx_reg;
    assign ry_out   = ry_reg;
    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;

endmodule

`default_nettype wire
